>>> hdl/white_reference_pixel_stats_core_assert.svh
// Assertion macros for the white reference pixel statistics core.
// Included by the top level only; it needs no package.
`ifndef WHITE_REFERENCE_PIXEL_STATS_CORE_ASSERT_SVH
`define WHITE_REFERENCE_PIXEL_STATS_CORE_ASSERT_SVH

// Same-cycle implication under an active-low reset.
`define WRPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under an active-low reset.
`define WRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/wrps_pkg.sv
// Shared types, constants and register codes of the white reference pixel statistics core.
// Used by every module of the block; depends on nothing.
package wrps_pkg;

	localparam int unsigned MAX_ROWS = 1024;
	localparam int unsigned MAX_COLS = 1024;
	localparam int unsigned HW_COUNT_CAP = 1048576;
	localparam int unsigned COUNT_LIMIT =
		(MAX_ROWS * MAX_COLS < HW_COUNT_CAP) ? MAX_ROWS * MAX_COLS : HW_COUNT_CAP;

	localparam int unsigned COUNT_W     = 21;
	localparam int unsigned CH_SUM_W    = 28;
	localparam int unsigned LUMA_SUM_W  = 38;
	localparam int unsigned LUMA_TERM_W = 18;
	localparam int unsigned MEAN_W      = 16;

	localparam int unsigned DIV_NUM_W = 38;
	localparam int unsigned DIV_DEN_W = 23;
	localparam int unsigned DIV_Q_W   = 16;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_Q_W);

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [2:0] REG_REFERENCE_ROW    = 3'd0;
	localparam logic [2:0] REG_BAND_HALF_HEIGHT = 3'd1;
	localparam logic [2:0] REG_FRAME_ROWS       = 3'd2;
	localparam logic [2:0] REG_MAX_SATURATION   = 3'd3;
	localparam logic [2:0] REG_VALUE_FLOOR      = 3'd4;
	localparam logic [2:0] REG_MIN_CHANNEL      = 3'd5;
	localparam logic [2:0] REG_MAX_SPREAD       = 3'd6;

	localparam logic [1:0] MEAN_BLUE  = 2'd0;
	localparam logic [1:0] MEAN_GREEN = 2'd1;
	localparam logic [1:0] MEAN_RED   = 2'd2;
	localparam logic [1:0] MEAN_LUMA  = 2'd3;

	typedef struct packed {
		logic [9:0]  reference_row;
		logic [9:0]  band_half_height;
		logic [10:0] frame_rows;
		logic [7:0]  max_saturation;
		logic [7:0]  value_floor;
		logic [7:0]  min_channel;
		logic [7:0]  max_spread;
	} cfg_t;

	typedef struct packed {
		logic                   white;
		logic                   last;
		logic [7:0]             blue;
		logic [7:0]             green;
		logic [7:0]             red;
		logic [LUMA_TERM_W-1:0] luma;
	} q_item_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [DIV_Q_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic              valid_res;
		logic [COUNT_W-1:0] pixel_count;
		logic [MEAN_W-1:0] mean_blue;
		logic [MEAN_W-1:0] mean_green;
		logic [MEAN_W-1:0] mean_red;
		logic [MEAN_W-1:0] luma_mean;
	} res_t;

	typedef enum logic [1:0] {
		BK_ACC,
		BK_LAUNCH,
		BK_WAIT,
		BK_EMIT
	} back_state_t;

endpackage

>>> hdl/white_reference_pixel_stats_core.sv
// Top level of the white reference pixel statistics core: configuration registers and wiring.
// Depends on wrps_pkg, wrps_front, wrps_queue, wrps_back, wrps_div and the assertion header.
`include "white_reference_pixel_stats_core_assert.svh"

// The core takes a frame's BGR pixels in raster order, one word per push, each
// with its row index, and flags a pixel as white when its row lies in the band
// around the reference row and its saturation, value, smallest channel and
// channel spread pass the configured limits. White pixels add to per-channel
// sums, a Q10 luma sum and a count. The pixel marked frame_end is counted like
// any other, and then one result word comes out: whether any white pixel was
// seen, the count, and the Q8.8 rounded means of blue, green, red and luma.
// Pixels are taken at one per clock while the frame streams; full rises only
// when the four-entry queue between the classifier and the accumulator fills.
// After a frame-end pixel leaves the queue the accumulator works out the four
// means, which run one after another through a single serial divider at one
// quotient bit per clock, each quotient then latched into its mean register;
// incoming pixels meanwhile wait in the queue.
// The result sits in an output register until popped, so the next frame can
// stream in while it waits; a second frame end stalls only if the earlier
// result has not yet been taken. Registers are written through the cfg port,
// which is always ready, and should only be changed while no frame is in
// flight. Indices beyond the register list are ignored.
module white_reference_pixel_stats_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  blue,
	input  logic [7:0]  green,
	input  logic [7:0]  red,
	input  logic [9:0]  row,
	input  logic        frame_end,
	input  logic        pop,
	output logic        empty,
	output logic        valid_res,
	output logic [20:0] pixel_count,
	output logic [15:0] mean_blue,
	output logic [15:0] mean_green,
	output logic [15:0] mean_red,
	output logic [15:0] luma_mean,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data
);
	import wrps_pkg::*;

	cfg_t     cfg_q;
	q_item_t  front_item;
	q_item_t  q_item;
	logic     q_full;
	logic     q_empty;
	logic     q_push;
	logic     q_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;
	res_t     res;
	logic     res_blank;

	// The registers take a write whenever one is offered, so the port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reference_row    <= 10'd0;
			cfg_q.band_half_height <= 10'd0;
			cfg_q.frame_rows       <= 11'd480;
			cfg_q.max_saturation   <= 8'd255;
			cfg_q.value_floor      <= 8'd0;
			cfg_q.min_channel      <= 8'd0;
			cfg_q.max_spread       <= 8'd255;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_REFERENCE_ROW:    cfg_q.reference_row    <= cfg_data[9:0];
				REG_BAND_HALF_HEIGHT: cfg_q.band_half_height <= cfg_data[9:0];
				REG_FRAME_ROWS:       cfg_q.frame_rows       <= cfg_data;
				REG_MAX_SATURATION:   cfg_q.max_saturation   <= cfg_data[7:0];
				REG_VALUE_FLOOR:      cfg_q.value_floor      <= cfg_data[7:0];
				REG_MIN_CHANNEL:      cfg_q.min_channel      <= cfg_data[7:0];
				REG_MAX_SPREAD:       cfg_q.max_spread       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// The classifier works on the pixel as it is pushed; the queue stores
	// the verdict together with the channel values and the luma term.
	wrps_front u_front (
		.cfg       (cfg_q),
		.blue      (blue),
		.green     (green),
		.red       (red),
		.row       (row),
		.frame_end (frame_end),
		.item      (front_item)
	);

	assign full   = q_full;
	assign q_push = push && !q_full;

	wrps_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_item (front_item),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_item (q_item),
		.empty   (q_empty)
	);

	wrps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.res       (res),
		.res_empty (empty),
		.res_pop   (pop)
	);

	wrps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign valid_res   = res.valid_res;
	assign pixel_count = res.pixel_count;
	assign mean_blue   = res.mean_blue;
	assign mean_green  = res.mean_green;
	assign mean_red    = res.mean_red;
	assign luma_mean   = res.luma_mean;

	// A result word with no statistics in it: flag and all four means clear.
	assign res_blank = !valid_res && mean_blue == '0 && mean_green == '0 &&
		mean_red == '0 && luma_mean == '0;

	// The back part must never start a division while the divider is still running.
	`WRPS_ASSERT_IMP(a_div_start_idle, clk, arst_n, div_req.start, !div_rsp.busy, "divider started while busy")
	// A started division keeps the divider busy in the following cycle.
	`WRPS_ASSERT_NEXT(a_div_runs, clk, arst_n, div_req.start, div_rsp.busy && !div_rsp.done, "divider did not start")
	// The accumulator only takes entries that the queue actually holds.
	`WRPS_ASSERT_IMP(a_pop_nonempty, clk, arst_n, q_pop, !q_empty, "queue popped while empty")
	// A frame without white pixels reports no statistics.
	`WRPS_ASSERT_IMP(a_empty_frame, clk, arst_n, !empty && pixel_count == '0, res_blank, "nonzero result for a frame without white pixels")

endmodule

>>> hdl/wrps_front.sv
// Front part: classifies one pixel as white or not and forms its queue entry.
// Depends on wrps_pkg.
module wrps_front (
	input  wrps_pkg::cfg_t    cfg,
	input  logic [7:0]        blue,
	input  logic [7:0]        green,
	input  logic [7:0]        red,
	input  logic [9:0]        row,
	input  logic              frame_end,
	output wrps_pkg::q_item_t item
);
	import wrps_pkg::*;

	logic [7:0]  mx;
	logic [7:0]  mn;
	logic [7:0]  spread;
	logic [15:0] sat_lhs;
	logic [16:0] sat_rhs;
	logic        sat_ok;
	logic [10:0] rows_eff;
	logic [10:0] last_row;
	logic [10:0] centre;
	logic [10:0] band_lo;
	logic [11:0] hi_sum;
	logic [10:0] band_hi;
	logic        band_ok;

	always_comb begin
		mx = blue;
		mn = blue;
		if (green > mx) mx = green;
		if (red > mx) mx = red;
		if (green < mn) mn = green;
		if (red < mn) mn = red;
		spread = mx - mn;

		// Rounded saturation <= limit is the same as 255*spread + max/2 < (limit+1)*max.
		sat_lhs = {spread, 8'h00} - {8'h00, spread} + {9'b0, mx[7:1]};
		sat_rhs = 17'({1'b0, cfg.max_saturation} + 9'd1) * 17'(mx);
		sat_ok  = (mx == 8'd0) || ({1'b0, sat_lhs} < sat_rhs);

		if (32'(cfg.frame_rows) > MAX_ROWS) begin
			rows_eff = 11'(MAX_ROWS);
		end else begin
			rows_eff = cfg.frame_rows;
		end
		last_row = rows_eff - 11'd1;
		centre   = ({1'b0, cfg.reference_row} < last_row) ? {1'b0, cfg.reference_row} : last_row;
		band_lo  = (centre > {1'b0, cfg.band_half_height}) ?
			centre - {1'b0, cfg.band_half_height} : 11'd0;
		hi_sum   = {1'b0, centre} + {2'b0, cfg.band_half_height};
		band_hi  = (hi_sum > {1'b0, last_row}) ? last_row : hi_sum[10:0];
		band_ok  = (rows_eff != 11'd0) && ({1'b0, row} >= band_lo) && ({1'b0, row} <= band_hi);

		item.white = band_ok && sat_ok && (mx >= cfg.value_floor) &&
			(mn >= cfg.min_channel) && (spread <= cfg.max_spread);
		item.last  = frame_end;
		item.blue  = blue;
		item.green = green;
		item.red   = red;
		item.luma  = LUMA_TERM_W'(red) * LUMA_TERM_W'(306) +
			LUMA_TERM_W'(green) * LUMA_TERM_W'(601) +
			LUMA_TERM_W'(blue) * LUMA_TERM_W'(117);
	end

endmodule

>>> hdl/wrps_queue.sv
// Short queue of classified pixels between the front and the back part.
// Depends on wrps_pkg.
module wrps_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  wrps_pkg::q_item_t wr_item,
	output logic              full,
	input  logic              rd_en,
	output wrps_pkg::q_item_t rd_item,
	output logic              empty
);
	import wrps_pkg::*;

	q_item_t           slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign full    = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (fill_q == '0);
	assign rd_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				fill_q <= fill_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/wrps_div.sv
// Serial restoring divider, one quotient bit per cycle, shared by the four means.
// Depends on wrps_pkg.
module wrps_div (
	input  logic               clk,
	input  logic               arst_n,
	input  wrps_pkg::div_req_t req,
	output wrps_pkg::div_rsp_t rsp
);
	import wrps_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_Q_W-1:0]   shf_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	// The caller guarantees that the quotient fits, so the upper numerator
	// bits start below the divisor and the remainder stays narrow.
	always_comb begin
		trial = {rem_q, shf_q[DIV_Q_W-1]};
		ge    = (trial >= {1'b0, den_q});
		diff  = trial - {1'b0, den_q};
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = shf_q;

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= DIV_DEN_W'(req.num[DIV_NUM_W-1:DIV_Q_W]);
			shf_q <= req.num[DIV_Q_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			shf_q <= {shf_q[DIV_Q_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == DIV_CNT_W'(DIV_Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> hdl/wrps_back.sv
// Back part: accumulates white pixels, sequences the mean divisions and holds the result.
// Depends on wrps_pkg; drives the shared divider wrps_div.
module wrps_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  wrps_pkg::q_item_t  q_item,
	output logic               q_pop,
	output wrps_pkg::div_req_t div_req,
	input  wrps_pkg::div_rsp_t div_rsp,
	output wrps_pkg::res_t     res,
	output logic               res_empty,
	input  logic               res_pop
);
	import wrps_pkg::*;

	back_state_t             state_q;
	back_state_t             state_d;
	logic [CH_SUM_W-1:0]     blue_sum_q;
	logic [CH_SUM_W-1:0]     green_sum_q;
	logic [CH_SUM_W-1:0]     red_sum_q;
	logic [LUMA_SUM_W-1:0]   luma_sum_q;
	logic [COUNT_W-1:0]      count_q;
	logic [1:0]              idx_q;
	logic [MEAN_W-1:0]       mean_q [4];
	logic                    res_valid_q;
	res_t                    res_q;
	logic                    acc_add;
	logic                    acc_clr;
	logic                    store_mean;
	logic                    load_res;
	logic                    div_start;
	logic [CH_SUM_W-1:0]     sel_sum;
	logic                    has_white;

	assign has_white = (count_q != '0);

	always_comb begin
		case (idx_q)
			MEAN_BLUE:  sel_sum = blue_sum_q;
			MEAN_GREEN: sel_sum = green_sum_q;
			MEAN_RED:   sel_sum = red_sum_q;
			default:    sel_sum = blue_sum_q;
		endcase
		div_req.start = div_start;
		// Channels divide sum*256 by the count, luma divides its sum by four times the count.
		// Half the divisor is added first for round-half-up.
		if (idx_q == MEAN_LUMA) begin
			div_req.num = luma_sum_q + DIV_NUM_W'({count_q, 1'b0});
			div_req.den = DIV_DEN_W'({count_q, 2'b00});
		end else begin
			div_req.num = DIV_NUM_W'({sel_sum, 8'h00}) + DIV_NUM_W'(count_q[COUNT_W-1:1]);
			div_req.den = DIV_DEN_W'(count_q);
		end
	end

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		acc_add    = 1'b0;
		acc_clr    = 1'b0;
		store_mean = 1'b0;
		load_res   = 1'b0;
		div_start  = 1'b0;
		case (state_q)
			BK_ACC: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					acc_add = q_item.white && (count_q < COUNT_W'(COUNT_LIMIT));
					if (q_item.last) begin
						state_d = BK_LAUNCH;
					end
				end
			end
			BK_LAUNCH: begin
				div_start = 1'b1;
				state_d   = BK_WAIT;
			end
			BK_WAIT: begin
				if (div_rsp.done) begin
					store_mean = 1'b1;
					state_d    = (idx_q == MEAN_LUMA) ? BK_EMIT : BK_LAUNCH;
				end
			end
			BK_EMIT: begin
				if (!res_valid_q || res_pop) begin
					load_res = 1'b1;
					acc_clr  = 1'b1;
					state_d  = BK_ACC;
				end
			end
			default: state_d = BK_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_ACC;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blue_sum_q  <= '0;
			green_sum_q <= '0;
			red_sum_q   <= '0;
			luma_sum_q  <= '0;
			count_q     <= '0;
			idx_q       <= MEAN_BLUE;
			res_valid_q <= 1'b0;
		end else begin
			if (acc_clr) begin
				blue_sum_q  <= '0;
				green_sum_q <= '0;
				red_sum_q   <= '0;
				luma_sum_q  <= '0;
				count_q     <= '0;
			end else if (acc_add) begin
				blue_sum_q  <= blue_sum_q + CH_SUM_W'(q_item.blue);
				green_sum_q <= green_sum_q + CH_SUM_W'(q_item.green);
				red_sum_q   <= red_sum_q + CH_SUM_W'(q_item.red);
				luma_sum_q  <= luma_sum_q + LUMA_SUM_W'(q_item.luma);
				count_q     <= count_q + 1'b1;
			end
			if (store_mean) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_mean) begin
			mean_q[idx_q] <= div_rsp.quotient;
		end
		if (load_res) begin
			res_q.valid_res   <= has_white;
			res_q.pixel_count <= count_q;
			res_q.mean_blue   <= has_white ? mean_q[MEAN_BLUE] : '0;
			res_q.mean_green  <= has_white ? mean_q[MEAN_GREEN] : '0;
			res_q.mean_red    <= has_white ? mean_q[MEAN_RED] : '0;
			res_q.luma_mean   <= has_white ? mean_q[MEAN_LUMA] : '0;
		end
	end

	assign res       = res_q;
	assign res_empty = !res_valid_q;

endmodule

>>> tb/white_reference_pixel_stats_core_tb.sv
// Self-checking testbench for white_reference_pixel_stats_core: frames of pixels are
// pushed in, every frame result is checked against a behavioral predictor in this file.
// Depends on wrps_pkg and the core RTL only.
module white_reference_pixel_stats_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wrps_pkg::*;

	// Register index that the core must ignore.
	localparam logic [2:0] REG_UNUSED = 3'd7;
	// Cycles allowed after the last result word before the core counts as idle. The
	// four serial divisions of a result take far less, so this leaves a wide margin.
	localparam int DRAIN_CYCLES = 150;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_PIXELS = 250;

	typedef enum {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_t;

	// One pixel word as it is driven on the input ports.
	typedef struct packed {
		bit [7:0] blue;
		bit [7:0] green;
		bit [7:0] red;
		bit [9:0] row_idx;
		bit       last;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  blue = '0;
	logic [7:0]  green = '0;
	logic [7:0]  red = '0;
	logic [9:0]  row = '0;
	logic        frame_end = 1'b0;
	logic        pop = 1'b0;
	logic        empty;
	logic        valid_res;
	logic [20:0] pixel_count;
	logic [15:0] mean_blue;
	logic [15:0] mean_green;
	logic [15:0] mean_red;
	logic [15:0] luma_mean;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [10:0] cfg_data = '0;

	// Pixels waiting to be driven, the one on the ports now, and whether it is still
	// waiting for the core to take it.
	pixel_t pending_pixels[$];
	pixel_t shown_pixel;
	bit     shown_waiting = 1'b0;

	// Expected frame results, oldest first.
	res_t frame_results[$];

	// Predictor copy of the configuration and the running white-pixel sums.
	cfg_t       settings;
	bit [27:0]  blue_acc;
	bit [27:0]  green_acc;
	bit [27:0]  red_acc;
	bit [37:0]  luma_acc;
	bit [20:0]  white_total;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned failures = 0;

	white_reference_pixel_stats_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.blue         (blue),
		.green        (green),
		.red          (red),
		.row          (row),
		.frame_end    (frame_end),
		.pop          (pop),
		.empty        (empty),
		.valid_res    (valid_res),
		.pixel_count  (pixel_count),
		.mean_blue    (mean_blue),
		.mean_green   (mean_green),
		.mean_red     (mean_red),
		.luma_mean    (luma_mean),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// The band is centered on the reference row, clamped into the frame. The frame
	// height itself is limited to MAX_ROWS, and a height of zero makes the band empty.
	function automatic bit row_in_band(bit [9:0] r);
		int unsigned rows, last_row, centre, lo, hi;
		rows = settings.frame_rows;
		if (rows > MAX_ROWS) begin
			rows = MAX_ROWS;
		end
		if (rows == 0) begin
			return 1'b0;
		end
		last_row = rows - 1;
		centre = (settings.reference_row < last_row) ? settings.reference_row : last_row;
		lo = (centre > settings.band_half_height) ? centre - settings.band_half_height : 0;
		hi = centre + settings.band_half_height;
		if (hi > last_row) begin
			hi = last_row;
		end
		return (r >= lo) && (r <= hi);
	endfunction

	// HSV saturation is rounded half up, and a black pixel has saturation zero.
	function automatic bit is_white(pixel_t px);
		int unsigned mx, mn, spread, sat;
		mx = px.blue;
		mn = px.blue;
		if (px.green > mx) mx = px.green;
		if (px.red > mx) mx = px.red;
		if (px.green < mn) mn = px.green;
		if (px.red < mn) mn = px.red;
		spread = mx - mn;
		sat = (mx == 0) ? 0 : (255 * spread + mx / 2) / mx;
		return row_in_band(px.row_idx) && sat <= settings.max_saturation &&
			mx >= settings.value_floor && mn >= settings.min_channel &&
			spread <= settings.max_spread && white_total < COUNT_LIMIT;
	endfunction

	// Rounded-half-up quotient cut to a Q8.8 word; zero when there is nothing to divide by.
	function automatic bit [15:0] q88_round(bit [63:0] num, bit [63:0] den);
		bit [63:0] q;
		if (den == 0) begin
			return '0;
		end
		q = (num + den / 2) / den;
		return q[15:0];
	endfunction

	function automatic void clear_sums();
		blue_acc = '0;
		green_acc = '0;
		red_acc = '0;
		luma_acc = '0;
		white_total = '0;
	endfunction

	// The frame-end pixel is classified and counted before the frame result is formed.
	function automatic void take_pixel(pixel_t px);
		res_t stats;
		if (is_white(px)) begin
			blue_acc += 28'(px.blue);
			green_acc += 28'(px.green);
			red_acc += 28'(px.red);
			luma_acc += 38'(306 * px.red) + 38'(601 * px.green) + 38'(117 * px.blue);
			white_total += 21'd1;
		end
		if (px.last) begin
			stats.valid_res = (white_total != 0);
			stats.pixel_count = white_total;
			stats.mean_blue = q88_round(64'(blue_acc) << 8, 64'(white_total));
			stats.mean_green = q88_round(64'(green_acc) << 8, 64'(white_total));
			stats.mean_red = q88_round(64'(red_acc) << 8, 64'(white_total));
			stats.luma_mean = q88_round(64'(luma_acc), 64'(white_total) * 4);
			frame_results.insert(frame_results.size(), stats);
			clear_sums();
		end
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [10:0] data);
		case (idx)
			REG_REFERENCE_ROW:    settings.reference_row = data[9:0];
			REG_BAND_HALF_HEIGHT: settings.band_half_height = data[9:0];
			REG_FRAME_ROWS:       settings.frame_rows = data;
			REG_MAX_SATURATION:   settings.max_saturation = data[7:0];
			REG_VALUE_FLOOR:      settings.value_floor = data[7:0];
			REG_MIN_CHANNEL:      settings.min_channel = data[7:0];
			REG_MAX_SPREAD:       settings.max_spread = data[7:0];
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driver and monitor
	// ------------------------------------------------------------------

	// A pixel word is accepted at a rising edge with push high and full low. The
	// prediction is updated at that same edge, from the word that was on the ports.
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			take_pixel(shown_pixel);
			shown_waiting = 1'b0;
		end
	end

	// A word stays on the ports until it is taken. Once taken, the next one is
	// either shown right away or held back, as the pace asks.
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!shown_waiting) begin
			if (pending_pixels.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				shown_pixel = pending_pixels.pop_front();
				shown_waiting = 1'b1;
				blue <= shown_pixel.blue;
				green <= shown_pixel.green;
				red <= shown_pixel.red;
				row <= shown_pixel.row_idx;
				frame_end <= shown_pixel.last;
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// The receiver side stalls at random, independent of whether a result is waiting.
	always @(negedge clk) begin
		pop <= ($urandom_range(99, 0) >= recv_stall_pct);
	end

	function automatic void check_field(string name, longint unsigned want,
		longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	// Every result word popped from the core is matched against the oldest prediction.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			if (frame_results.size() == 0) begin
				$error("result word popped while no frame result was expected");
				failures++;
			end else begin
				want = frame_results.pop_front();
				check_field("valid_res", want.valid_res, valid_res);
				check_field("pixel_count", want.pixel_count, pixel_count);
				check_field("mean_blue", want.mean_blue, mean_blue);
				check_field("mean_green", want.mean_green, mean_green);
				check_field("mean_red", want.mean_red, mean_red);
				check_field("luma_mean", want.luma_mean, luma_mean);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	task automatic write_reg(logic [2:0] idx, logic [10:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_pace(pace_t pace);
		case (pace)
			PACE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			PACE_SEND: begin
				send_idle_pct = 81;
				recv_stall_pct = 0;
			end
			PACE_RECV: begin
				send_idle_pct = 0;
				recv_stall_pct = 81;
			end
			default: begin
				send_idle_pct = 8;
				recv_stall_pct = 8;
			end
		endcase
	endtask

	function automatic void queue_pixel(bit [7:0] b, bit [7:0] g, bit [7:0] r,
		bit [9:0] ri, bit last);
		pixel_t px;
		px.blue = b;
		px.green = g;
		px.red = r;
		px.row_idx = ri;
		px.last = last;
		pending_pixels.insert(pending_pixels.size(), px);
	endfunction

	// A phase ends once every pixel word is taken and every frame result has come
	// back; then the core is given time to settle before any register changes.
	task automatic finish_phase();
		while (pending_pixels.size() != 0 || shown_waiting || frame_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly a random value in the typical range, now and then one of the extremes.
	function automatic int unsigned pick(int unsigned lo_end, int unsigned hi_end,
		int unsigned typ_lo, int unsigned typ_hi);
		case ($urandom_range(5, 0))
			0: return lo_end;
			1: return hi_end;
			default: return $urandom_range(typ_hi, typ_lo);
		endcase
	endfunction

	// Writes all seven registers. Data bits above a register's width are filled with
	// noise, since the core has to drop them.
	task automatic randomize_settings();
		int unsigned rows;
		rows = pick(1, 1024, 1, 1024);
		if ($urandom_range(7, 0) == 0) begin
			rows = $urandom_range(1, 0) ? 0 : 2047;
		end
		write_reg(REG_REFERENCE_ROW, {$urandom_range(1, 0) == 1, 10'(pick(0, 1023, 0, 1023))});
		write_reg(REG_BAND_HALF_HEIGHT,
			{$urandom_range(1, 0) == 1, 10'(pick(0, 1023, 0, 40))});
		write_reg(REG_FRAME_ROWS, 11'(rows));
		write_reg(REG_MAX_SATURATION, {3'($urandom), 8'(pick(0, 255, 20, 120))});
		write_reg(REG_VALUE_FLOOR, {3'($urandom), 8'(pick(0, 255, 60, 200))});
		write_reg(REG_MIN_CHANNEL, {3'($urandom), 8'(pick(0, 255, 40, 180))});
		write_reg(REG_MAX_SPREAD, {3'($urandom), 8'(pick(0, 255, 10, 80))});
	endtask

	// Half the pixels are near-gray so that the thresholds actually get exercised,
	// the rest are noise or saturated extremes. Two rows in three land near the band.
	function automatic pixel_t make_pixel(bit last);
		pixel_t px;
		int unsigned base, d, lo, hi, kind;
		kind = $urandom_range(9, 0);
		if (kind < 5) begin
			base = $urandom_range(255, 0);
			d = $urandom_range(40, 0);
			if (d > base) d = base;
			px.blue = 8'(base - $urandom_range(d, 0));
			px.green = 8'(base - $urandom_range(d, 0));
			px.red = 8'(base - $urandom_range(d, 0));
		end else if (kind < 8) begin
			px.blue = 8'($urandom_range(255, 0));
			px.green = 8'($urandom_range(255, 0));
			px.red = 8'($urandom_range(255, 0));
		end else begin
			px.blue = $urandom_range(1, 0) ? 8'd255 : 8'd0;
			px.green = $urandom_range(1, 0) ? 8'd255 : 8'd0;
			px.red = $urandom_range(1, 0) ? 8'd255 : 8'd0;
		end
		if ($urandom_range(2, 0) != 0) begin
			lo = settings.reference_row;
			hi = lo + settings.band_half_height + 2;
			lo = (lo > settings.band_half_height + 2) ? lo - settings.band_half_height - 2 : 0;
			if (hi > 1023) hi = 1023;
			px.row_idx = 10'($urandom_range(hi, lo));
		end else begin
			px.row_idx = 10'($urandom_range(1023, 0));
		end
		px.last = last;
		return px;
	endfunction

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin
		int queued, len;

		settings.reference_row = '0;
		settings.band_half_height = '0;
		settings.frame_rows = 11'd480;
		settings.max_saturation = 8'd255;
		settings.value_floor = '0;
		settings.min_channel = '0;
		settings.max_spread = 8'd255;
		clear_sums();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// With the reset settings only row 0 is in the band and every threshold is
		// wide open: black, full white and a pure channel all count; rows 1 and
		// 1023 do not.
		set_pace(PACE_NONE);
		queue_pixel(8'd0, 8'd0, 8'd0, 10'd0, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 10'd0, 1'b0);
		queue_pixel(8'd255, 8'd0, 8'd0, 10'd0, 1'b0);
		queue_pixel(8'd0, 8'd255, 8'd0, 10'd1, 1'b0);
		queue_pixel(8'd0, 8'd0, 8'd255, 10'd1023, 1'b0);
		queue_pixel(8'd128, 8'd64, 8'd32, 10'd0, 1'b1);
		finish_phase();

		// A one-pixel frame with nothing white gives a result word of zeros.
		set_pace(PACE_SEND);
		queue_pixel(8'd10, 8'd20, 8'd30, 10'd5, 1'b1);
		finish_phase();

		// Tightest thresholds with the widest band and a frame height beyond
		// MAX_ROWS: only pure white passes, on any row.
		set_pace(PACE_RECV);
		write_reg(REG_REFERENCE_ROW, 11'd1023);
		write_reg(REG_BAND_HALF_HEIGHT, 11'd1023);
		write_reg(REG_FRAME_ROWS, 11'd2047);
		write_reg(REG_MAX_SATURATION, 11'd0);
		write_reg(REG_VALUE_FLOOR, 11'd255);
		write_reg(REG_MIN_CHANNEL, 11'd255);
		write_reg(REG_MAX_SPREAD, 11'd0);
		queue_pixel(8'd255, 8'd255, 8'd255, 10'd0, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 10'd1023, 1'b0);
		queue_pixel(8'd254, 8'd255, 8'd255, 10'd500, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 10'd512, 1'b1);
		finish_phase();

		// A frame height of zero leaves the band empty.
		set_pace(PACE_BOTH);
		write_reg(REG_FRAME_ROWS, 11'd0);
		queue_pixel(8'd255, 8'd255, 8'd255, 10'd0, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 10'd0, 1'b1);
		finish_phase();

		// A reference row past the last frame row is pulled back to row 99, so the
		// band is rows 94 to 99 and its edges are probed from both sides.
		set_pace(PACE_NONE);
		write_reg(REG_FRAME_ROWS, 11'd100);
		write_reg(REG_BAND_HALF_HEIGHT, 11'd5);
		write_reg(REG_MAX_SATURATION, 11'd255);
		write_reg(REG_VALUE_FLOOR, 11'd0);
		write_reg(REG_MIN_CHANNEL, 11'd0);
		write_reg(REG_MAX_SPREAD, 11'd255);
		queue_pixel(8'd200, 8'd200, 8'd200, 10'd93, 1'b0);
		queue_pixel(8'd200, 8'd201, 8'd202, 10'd94, 1'b0);
		queue_pixel(8'd90, 8'd100, 8'd110, 10'd99, 1'b0);
		queue_pixel(8'd200, 8'd200, 8'd200, 10'd100, 1'b1);
		finish_phase();

		// Saturation rounding right at the limit: 255/127/127 rounds to 128 and fails,
		// 255/128/128 rounds to 127 and passes. A one-row frame keeps only row 0. The
		// write to the unused index must leave every register alone.
		write_reg(REG_FRAME_ROWS, 11'd1);
		write_reg(REG_REFERENCE_ROW, 11'd0);
		write_reg(REG_BAND_HALF_HEIGHT, 11'd1023);
		write_reg(REG_MAX_SATURATION, 11'd127);
		write_reg(REG_UNUSED, 11'd2047);
		queue_pixel(8'd255, 8'd127, 8'd127, 10'd0, 1'b0);
		queue_pixel(8'd255, 8'd128, 8'd128, 10'd0, 1'b0);
		queue_pixel(8'd1, 8'd0, 8'd0, 10'd0, 1'b1);
		finish_phase();

		// Random part: every phase picks fresh settings and a pace, then streams
		// whole frames of random length, now and then a long one.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_pace(pace_t'(p % 4));
			randomize_settings();
			queued = 0;
			while (queued < PHASE_PIXELS) begin
				len = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 40) : $urandom_range(24, 1);
				for (int i = 0; i < len; i++) begin
					pending_pixels.insert(pending_pixels.size(), make_pixel(i == len - 1));
				end
				queued += len;
			end
			finish_phase();
		end

		failures += frame_results.size();
		if (failures == 0) begin
			$display("white_reference_pixel_stats_core test passed");
		end else begin
			$display("white_reference_pixel_stats_core test failed");
		end
		$finish;
	end

	// Hard limit well beyond the slowest correct run.
	initial begin
		#(20_000_000);
		$display("white_reference_pixel_stats_core test failed");
		$finish;
	end

endmodule

>>> white_reference_pixel_stats_core.f
+incdir+hdl
hdl/wrps_pkg.sv
hdl/wrps_front.sv
hdl/wrps_queue.sv
hdl/wrps_div.sv
hdl/wrps_back.sv
hdl/white_reference_pixel_stats_core.sv
tb/white_reference_pixel_stats_core_tb.sv
